[src/assert_macros.svh]
// Assertion helper macros shared by the RTL files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed");
`endif

[src/dhht_pkg.sv]
// Shared types and constants for the device heartbeat health tracker.
// No dependencies.
`default_nettype none
package dhht_pkg;
    localparam int DevicesDefault = 64;
    localparam int TsW = 63;
    localparam int ToW = 48;
    localparam int MissW = 16;
    localparam logic [ToW-1:0] TimeoutReset = 48'd1000000000;
    localparam logic [MissW-1:0] MaxMissedReset = 16'd3;
    localparam logic [MissW-1:0] MissMax = 16'hFFFF;

    typedef enum logic [2:0] {
        H_HEALTHY = 3'd0, H_DEGRADED = 3'd1, H_SUSPECT = 3'd2,
        H_DEAD = 3'd3, H_RECOVERING = 3'd4
    } health_t;

    localparam logic [2:0] CMD_BEAT = 3'd0;
    localparam logic [2:0] CMD_TIMEOUT = 3'd1;
    localparam logic [2:0] CMD_ERROR = 3'd2;
    localparam logic [2:0] CMD_REPORT = 3'd3;
    localparam logic [2:0] CMD_CHECK = 3'd4;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_MAXMISS = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_EVAL, ST_DIV, ST_APPLY, ST_OUT
    } state_t;

    // divider control / status
    typedef struct packed {
        logic start;
    } div_ctl_t;
    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;
endpackage
`default_nettype wire

[src/device_heartbeat_health_tracker_top.sv]
// Device heartbeat health tracker, top level.
// Depends on dhht_pkg, dhht_ram, dhht_div, assert_macros.svh.
//
// Usage:
//  s_axis: one command beat (tdata = command[2:0], dev_id[10:3],
//  status_in[13:11], timestamp[76:14]). m_axis: result beats, tlast marks
//  the final beat of a command. A check command yields DEVICES beats, one per
//  device in id order; all other commands yield one beat.
//  Config: cfg_we/cfg_addr/cfg_wdata; index 0 heartbeat_timeout, 1 max_missed.
//  Timing: a single-device command steps through ST_READ, ST_EVAL, ST_DIV,
//  ST_APPLY and ST_OUT (an out-of-range id goes from ST_READ to ST_OUT); a
//  new command is taken after the last result beat is accepted. A check runs
//  these states per device and starts the bit-serial divider, the limiting
//  unit, for each device whose elapsed time exceeds the timeout. The tables
//  are three RAMs with one read/write port. s_tready is low while a command is
//  in work. A stalled m_tready holds the result beat and the sequence waits.
//  Reset clears control and sweeps the tables clear (s_tready low meanwhile).
`default_nettype none
`include "assert_macros.svh"
module device_heartbeat_health_tracker_top import dhht_pkg::*; #(
    parameter int Devices = DevicesDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // command[2:0], dev_id[10:3], status_in[13:11], timestamp[76:14]
    input  wire logic [79:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // result_device[7:0], in_range[8], health[11:9], event_valid[12],
    // mark_dead[13], mark_alive[14], missed_count[30:15]
    output logic [31:0]      m_tdata,
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [47:0] cfg_wdata
);
    localparam int AW = (Devices > 1) ? $clog2(Devices) : 1;

    state_t state_reg, state_next;
    logic [ToW-1:0] to_reg;
    logic [MissW-1:0] mm_reg;
    logic [2:0] cmd_reg, cmd_next;
    logic [7:0] dev_reg, dev_next;
    logic [2:0] st_reg, st_next;
    logic [TsW-1:0] now_reg, now_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic clr_reg, clr_next;
    logic [31:0] out_reg, out_next;
    logic last_reg, last_next;
    logic ovf_reg, ovf_next;
    logic [MissW:0] madd_reg, madd_next;

    // RAM ports
    logic we;
    logic [AW-1:0] addr;
    logic [2:0] h_w, h_r;
    logic [TsW-1:0] t_w, t_r;
    logic [MissW-1:0] m_w, m_r;
    logic h_we, t_we, m_we;

    dhht_ram #(.Width(3), .Depth(Devices)) u_h (
        .aclk, .we(h_we), .addr, .wdata(h_w), .rdata(h_r));
    dhht_ram #(.Width(TsW), .Depth(Devices)) u_t (
        .aclk, .we(t_we), .addr, .wdata(t_w), .rdata(t_r));
    dhht_ram #(.Width(MissW), .Depth(Devices)) u_m (
        .aclk, .we(m_we), .addr, .wdata(m_w), .rdata(m_r));

    div_ctl_t dctl;
    div_sts_t dsts;
    logic [MissW:0] quot;
    logic [ToW-1:0] to_eff;
    logic [TsW-1:0] elapsed;
    assign to_eff = (to_reg == '0) ? ToW'(1) : to_reg;
    assign elapsed = (now_reg > t_r) ? now_reg - t_r : '0;

    dhht_div u_div (.aclk, .aresetn, .ctl(dctl), .dividend(elapsed), .divisor(to_eff),
                    .sts(dsts), .quot);

    // config register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            to_reg <= TimeoutReset;
            mm_reg <= MaxMissedReset;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_TIMEOUT: to_reg <= cfg_wdata;
                REG_MAXMISS: mm_reg <= cfg_wdata[MissW-1:0];
                default: ;
            endcase
        end
    end

    logic inr;
    assign inr = ({24'd0, dev_reg} < 32'(Devices));

    // sequencer
    always_comb begin
        logic [2:0] nh;
        logic [MissW-1:0] miss;
        logic [MissW:0] sum;
        logic ev, timed, doesc;
        state_next = state_reg; cmd_next = cmd_reg; dev_next = dev_reg;
        st_next = st_reg; now_next = now_reg; idx_next = idx_reg; clr_next = clr_reg;
        out_next = out_reg; last_next = last_reg; ovf_next = ovf_reg; madd_next = madd_reg;
        h_we = 1'b0; t_we = 1'b0; m_we = 1'b0; we = 1'b0;
        addr = idx_reg; h_w = '0; t_w = '0; m_w = '0;
        dctl.start = 1'b0;
        s_tready = 1'b0;
        nh = h_r; miss = m_r; ev = 1'b0; timed = 1'b0; doesc = 1'b0;
        sum = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (clr_reg) begin
                    h_we = 1'b1; t_we = 1'b1; m_we = 1'b1;
                    if (32'(idx_reg) == Devices - 1) begin
                        clr_next = 1'b0;
                        idx_next = '0;
                    end else begin
                        idx_next = idx_reg + AW'(1);
                    end
                end else begin
                    s_tready = 1'b1;
                    if (s_tvalid) begin
                        cmd_next = s_tdata[2:0];
                        dev_next = s_tdata[10:3];
                        st_next = s_tdata[13:11];
                        now_next = s_tdata[76:14];
                        idx_next = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                // address is registered here; the registered read is valid in ST_DIV
                if (cmd_reg != CMD_CHECK) begin
                    idx_next = dev_reg[AW-1:0];
                end
                state_next = ST_EVAL;
                if (cmd_reg != CMD_CHECK && !inr) begin
                    out_next = {1'b0, 16'd0, 3'b000, H_DEAD, 1'b0, dev_reg};
                    last_next = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_EVAL: begin
                // RAM read in flight; data valid on ST_DIV entry
                state_next = ST_DIV;
                ovf_next = 1'b0;
                madd_next = '0;
            end
            ST_DIV: begin
                state_next = ST_APPLY;
                if (cmd_reg == CMD_CHECK && h_r != H_DEAD && t_r != '0 &&
                    elapsed > {15'd0, to_eff}) begin
                    if (!dsts.busy && !dsts.done && !ovf_reg) begin
                        dctl.start = 1'b1;
                        ovf_next = 1'b1;
                        state_next = ST_DIV;
                    end else if (dsts.done) begin
                        madd_next = (quot == '0) ? (MissW+1)'(1) : quot;
                        state_next = ST_APPLY;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_APPLY: begin
                we = 1'b1;
                if (cmd_reg == CMD_CHECK) begin
                    if (h_r != H_DEAD) begin
                        if (t_r == '0) begin
                            t_we = 1'b1; t_w = now_reg;
                        end else if (madd_reg != '0) begin
                            timed = 1'b1;
                        end
                    end
                end else begin
                    unique case (cmd_reg)
                        CMD_BEAT: begin
                            t_we = 1'b1; t_w = now_reg;
                            miss = '0;
                            if (h_r == H_SUSPECT || h_r == H_RECOVERING) begin
                                ev = 1'b1; nh = H_HEALTHY;
                            end else if (h_r == H_DEAD) begin
                                ev = 1'b1; nh = H_RECOVERING;
                            end
                        end
                        CMD_TIMEOUT: begin
                            if (h_r != H_DEAD) timed = 1'b1;
                        end
                        CMD_ERROR: begin
                            if (h_r != H_DEAD) begin
                                ev = 1'b1;
                                nh = (h_r == H_HEALTHY) ? H_DEGRADED : H_SUSPECT;
                            end
                        end
                        CMD_REPORT: begin
                            if (st_reg <= H_RECOVERING) begin
                                ev = 1'b1; nh = st_reg;
                            end
                        end
                        default: ;
                    endcase
                end
                if (timed) begin
                    sum = {1'b0, m_r} + ((cmd_reg == CMD_CHECK) ? madd_reg : (MissW+1)'(1));
                    miss = (sum[MissW] || madd_reg[MissW]) ? MissMax : sum[MissW-1:0];
                    if (h_r == H_HEALTHY || h_r == H_DEGRADED || h_r == H_RECOVERING) begin
                        ev = 1'b1; nh = H_SUSPECT;
                    end else if (h_r == H_SUSPECT && miss >= mm_reg) begin
                        ev = 1'b1; nh = H_DEAD;
                    end
                end
                if (ev && nh != H_SUSPECT) miss = '0;
                doesc = ev;
                h_we = 1'b1; h_w = nh;
                m_we = 1'b1; m_w = miss;
                out_next = {1'b0, miss, (nh == H_HEALTHY || nh == H_RECOVERING) && doesc,
                            (nh == H_DEAD) && doesc, doesc, nh, 1'b1,
                            (cmd_reg == CMD_CHECK) ? 8'(idx_reg) : dev_reg};
                last_next = (cmd_reg != CMD_CHECK) || (32'(idx_reg) == Devices - 1);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    if (last_reg) begin
                        state_next = ST_IDLE;
                        idx_next = '0;
                    end else begin
                        idx_next = idx_reg + AW'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (we) addr = idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            clr_reg <= 1'b1;
            idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            idx_reg <= idx_next;
        end
        cmd_reg <= cmd_next; dev_reg <= dev_next; st_reg <= st_next;
        now_reg <= now_next; out_reg <= out_next; last_reg <= last_next;
        ovf_reg <= ovf_next; madd_reg <= madd_next;
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata = out_reg;
    assign m_tlast = last_reg;

    `CHK_IMPL(a_busy_not_ready, aclk, aresetn, state_reg != ST_IDLE, !s_tready)
    `CHK_NEXT(a_out_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `CHK_IMPL(a_clear_quiet, aclk, aresetn, clr_reg, !m_tvalid)
endmodule
`default_nettype wire

[src/dhht_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module dhht_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  wire logic                                        aclk,
    input  wire logic                                        we,
    input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr,
    input  wire logic [Width-1:0]                            wdata,
    output logic [Width-1:0]                                 rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

[src/dhht_div.sv]
// Radix-2 restoring divider: 63-bit dividend by 48-bit divisor, one bit a cycle.
// Quotient saturated to 17 bits (anything above 65535 saturates later).
// Depends on dhht_pkg.
`default_nettype none
`include "assert_macros.svh"
module dhht_div import dhht_pkg::*; (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire div_ctl_t       ctl,
    input  wire logic [TsW-1:0] dividend,
    input  wire logic [ToW-1:0] divisor,
    output div_sts_t            sts,
    output logic [MissW:0]      quot
);
    logic [TsW-1:0] num_reg, num_next;
    logic [ToW:0] rem_reg, rem_next;
    logic [ToW-1:0] den_reg, den_next;
    logic [TsW-1:0] q_reg, q_next;
    logic [5:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic [ToW:0] sh;

    always_comb begin
        num_next = num_reg; rem_next = rem_reg; den_next = den_reg;
        q_next = q_reg; cnt_next = cnt_reg; busy_next = busy_reg;
        done_next = 1'b0;
        sh = {rem_reg[ToW-1:0], num_reg[TsW-1]};
        if (ctl.start) begin
            num_next = dividend; rem_next = '0; den_next = divisor;
            q_next = '0; cnt_next = 6'(TsW - 1); busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[TsW-2:0], 1'b0};
            if (sh >= {1'b0, den_reg}) begin
                rem_next = sh - {1'b0, den_reg};
                q_next = {q_reg[TsW-2:0], 1'b1};
            end else begin
                rem_next = sh;
                q_next = {q_reg[TsW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        num_reg <= num_next; rem_reg <= rem_next; den_reg <= den_next;
        q_reg <= q_next; cnt_reg <= cnt_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quot = (q_reg[TsW-1:MissW+1] != '0) ? {(MissW+1){1'b1}} : q_reg[MissW:0];

    `CHK_NEXT(a_done_after_busy, aclk, aresetn, done_reg, !busy_reg)
    `CHK_IMPL(a_no_start_busy, aclk, aresetn, ctl.start, !busy_reg)
    `CHK_IMPL(a_done_idle, aclk, aresetn, done_reg, !busy_reg)
endmodule
`default_nettype wire
